[design/tfs_pkg.sv]
// Package with the format codes and the HTML prefix tables of the text format sniffer.
`default_nettype none

package tfs_pkg;

  typedef enum logic [2:0] {
    FMT_JSON  = 3'd0,
    FMT_JSONL = 3'd1,
    FMT_YAML  = 3'd2,
    FMT_XML   = 3'd3,
    FMT_HTML  = 3'd4
  } format_t;

  localparam int PREFIX_COUNT = 5;

  // Each prefix is padded with spaces to 16 characters; the first character sits in the
  // top byte. Bytes past a prefix's length are never compared.
  localparam logic [127:0] PREFIX_TEXT [PREFIX_COUNT] = '{
    "<!doctype html  ",
    "<html           ",
    "<body           ",
    "<div            ",
    "<head           "
  };

  localparam logic [3:0] PREFIX_LEN [PREFIX_COUNT] = '{4'd14, 4'd5, 4'd5, 4'd4, 4'd5};

  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_BRACE  = 8'h7B;
  localparam logic [7:0] CHAR_ANGLE  = 8'h3C;
  localparam logic [7:0] CHAR_SQUARE = 8'h5B;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;

  localparam logic [3:0] POS_MAX   = 4'd15;
  localparam logic [1:0] LINES_MAX = 2'd2;

  // Character of a prefix at a given position within the padded text.
  function automatic logic [7:0] prefix_char(input logic [127:0] text, input logic [3:0] pos);
    logic [6:0] base;
    base = {~pos, 3'b000};
    return text[base +: 8];
  endfunction

  // ASCII A-Z are folded to lower case; every other byte passes unchanged.
  function automatic logic [7:0] fold_lower(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
      r = b + 8'd32;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[design/text_format_sniffer_unit.sv]
// Top level of the text format sniffer: byte-wise classifier of a document's format.
`default_nettype none

// The unit takes a document one word per cycle, each word being one text byte and a flag
// that marks the final byte, and returns one format code word after that final byte:
// 0 JSON, 1 JSONL, 2 YAML, 3 XML, 4 HTML. Leading space, tab, CR and LF are skipped; the
// first content bytes, lowercased for A-Z, are checked against the HTML openings
// "<!doctype html", "<html", "<body", "<div" and "<head". Failing that, a first '<' means
// XML, '[' means JSON, and '{' means JSONL when at least two non-blank lines exist and all
// of them start with '{', JSON otherwise. Any other start, or no content at all, is YAML.
// Rate: one input word is accepted every cycle. All per-byte work is a handful of compares
// that update the classification registers at the accepting edge; on the final byte the
// code is formed from the updated state and loaded into the output register, so it
// appears in the cycle after the final byte is accepted. The output register is the only
// thing that can hold off input: a new word is taken whenever that register is empty or
// is being drained in the same cycle. After the final byte all classification state
// returns to its reset values, so the next document may start in the following cycle.
module text_format_sniffer_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] text_byte,
  input  wire logic       end_of_text,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      format_code
);

  // Classification state.
  logic       content_started, content_started_next;
  logic [7:0] first_content_byte, first_content_byte_next;
  logic [3:0] content_position, content_position_next;
  logic [4:0] prefix_alive_mask, prefix_alive_mask_next;
  logic       in_line_lead, in_line_lead_next;
  logic [1:0] lines_seen, lines_seen_next;
  logic       all_lines_brace, all_lines_brace_next;

  logic       in_accept;
  logic       is_blank;
  logic       is_lf;
  logic       do_match;
  logic       do_count;
  logic [7:0] low_byte;
  tfs_pkg::format_t decision;

  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  assign is_blank = (text_byte == tfs_pkg::CHAR_SPACE) || (text_byte == tfs_pkg::CHAR_TAB) ||
                    (text_byte == tfs_pkg::CHAR_CR);
  assign is_lf    = (text_byte == tfs_pkg::CHAR_LF);
  assign low_byte = tfs_pkg::fold_lower(text_byte);

  // Every byte from the first content byte on is matched against the prefixes. A line is
  // counted at the document's first content byte and at the first non-blank byte after LF.
  assign do_match = content_started || (!is_blank && !is_lf);
  assign do_count = content_started ? (!is_lf && in_line_lead && !is_blank)
                                    : (!is_blank && !is_lf);

  // Next classification state for the byte at the input.
  always_comb begin
    content_started_next    = content_started || (!is_blank && !is_lf);
    first_content_byte_next = content_started ? first_content_byte : text_byte;
    content_position_next   = content_position;
    prefix_alive_mask_next  = prefix_alive_mask;
    in_line_lead_next       = in_line_lead;
    lines_seen_next         = lines_seen;
    all_lines_brace_next    = all_lines_brace;

    if (do_match && content_position != tfs_pkg::POS_MAX) begin
      for (int i = 0; i < tfs_pkg::PREFIX_COUNT; i++) begin
        if (content_position < tfs_pkg::PREFIX_LEN[i] &&
            low_byte != tfs_pkg::prefix_char(tfs_pkg::PREFIX_TEXT[i], content_position)) begin
          prefix_alive_mask_next[i] = 1'b0;
        end
      end
      content_position_next = content_position + 4'd1;
    end

    if (content_started && is_lf) begin
      in_line_lead_next = 1'b1;
    end

    if (do_count) begin
      if (lines_seen != tfs_pkg::LINES_MAX) begin
        lines_seen_next = lines_seen + 2'd1;
      end
      if (text_byte != tfs_pkg::CHAR_BRACE) begin
        all_lines_brace_next = 1'b0;
      end
      in_line_lead_next = 1'b0;
    end
  end

  // Format decision from the state as it stands after the final byte.
  always_comb begin
    logic html_hit;
    html_hit = 1'b0;
    for (int i = 0; i < tfs_pkg::PREFIX_COUNT; i++) begin
      if (prefix_alive_mask_next[i] && content_position_next >= tfs_pkg::PREFIX_LEN[i]) begin
        html_hit = 1'b1;
      end
    end

    if (!content_started_next) begin
      decision = tfs_pkg::FMT_YAML;
    end else if (html_hit) begin
      decision = tfs_pkg::FMT_HTML;
    end else if (first_content_byte_next == tfs_pkg::CHAR_ANGLE) begin
      decision = tfs_pkg::FMT_XML;
    end else if (first_content_byte_next == tfs_pkg::CHAR_SQUARE) begin
      decision = tfs_pkg::FMT_JSON;
    end else if (first_content_byte_next == tfs_pkg::CHAR_BRACE) begin
      if (all_lines_brace_next && lines_seen_next == tfs_pkg::LINES_MAX) begin
        decision = tfs_pkg::FMT_JSONL;
      end else begin
        decision = tfs_pkg::FMT_JSON;
      end
    end else begin
      decision = tfs_pkg::FMT_YAML;
    end
  end

  // Classification registers; the final byte returns them to their reset values.
  always_ff @(posedge clk) begin
    if (rst || (in_accept && end_of_text)) begin
      content_started    <= 1'b0;
      first_content_byte <= 8'd0;
      content_position   <= 4'd0;
      prefix_alive_mask  <= 5'h1F;
      in_line_lead       <= 1'b0;
      lines_seen         <= 2'd0;
      all_lines_brace    <= 1'b1;
    end else if (in_accept) begin
      content_started    <= content_started_next;
      first_content_byte <= first_content_byte_next;
      content_position   <= content_position_next;
      prefix_alive_mask  <= prefix_alive_mask_next;
      in_line_lead       <= in_line_lead_next;
      lines_seen         <= lines_seen_next;
      all_lines_brace    <= all_lines_brace_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && end_of_text) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && end_of_text) begin
      format_code <= decision;
    end
  end

  // The final byte always produces a result word in the next cycle.
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_accept && end_of_text |=> out_valid)
    else $error("final byte did not load the output register");

  // State is back at reset after the final byte.
  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    in_accept && end_of_text |=> !content_started && content_position == 4'd0 &&
                                 lines_seen == 2'd0 && prefix_alive_mask == 5'h1F &&
                                 all_lines_brace)
    else $error("classification state not cleared after final byte");

  // Position only advances once content has started.
  a_position_needs_content: assert property (@(posedge clk) disable iff (rst)
    content_position != 4'd0 |-> content_started)
    else $error("content position advanced without content");

  // Line count saturates at two.
  a_lines_saturate: assert property (@(posedge clk) disable iff (rst)
    lines_seen != 2'd3)
    else $error("line count exceeded saturation");

  // Result codes stay within the defined formats.
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> format_code <= 3'(tfs_pkg::FMT_HTML))
    else $error("format code out of range");

endmodule

`default_nettype wire

[test/tb_text_format_sniffer_unit.sv]
// Self-checking testbench for text_format_sniffer_unit, with a byte-level format predictor.
`timescale 1ns / 100ps

module tb_text_format_sniffer_unit;

  // The run is stopped after this many cycles.
  localparam int RUN_LIMIT    = 400000;
  localparam int RANDOM_BYTES = 850;
  localparam int DRAIN_CYCLES = 8;

  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

  logic       clk;
  logic       rst         = 1'b1;
  logic       in_valid    = 1'b0;
  logic       in_ready;
  logic [7:0] text_byte   = 8'h00;
  logic       end_of_text = 1'b0;
  logic       out_valid;
  logic       out_ready   = 1'b0;
  logic [2:0] format_code;

  text_format_sniffer_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .format_code (format_code)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------------------
  // Format predictor. It follows the document byte by byte with its own copy of
  // the classification state and queues one expected code per final byte.
  // ---------------------------------------------------------------------------
  logic       seen_content;
  logic [7:0] lead_byte;
  logic [3:0] content_count;
  logic [4:0] opening_alive;
  logic       at_line_start;
  logic [1:0] line_count;
  logic       lines_all_brace;

  tfs_pkg::format_t expected_codes [$];
  int      failures   = 0;
  int      bytes_sent = 0;
  int      cycle_count = 0;

  // The five HTML openings, lower case. Index order matches the alive mask bits.
  function automatic string opening_text(input int idx);
    case (idx)
      0:       return "<!doctype html";
      1:       return "<html";
      2:       return "<body";
      3:       return "<div";
      default: return "<head";
    endcase
  endfunction

  function void clear_sniff_state();
    seen_content    = 1'b0;
    lead_byte       = 8'h00;
    content_count   = 4'd0;
    opening_alive   = 5'h1F;
    at_line_start   = 1'b0;
    line_count      = 2'd0;
    lines_all_brace = 1'b1;
  endfunction

  // Every content byte after the first blank run is compared against all openings
  // still alive; the position counter stops at 15 and then nothing is compared.
  function void track_openings(input logic [7:0] b);
    logic [7:0] low;
    string      t;
    low = (b >= tfs_pkg::CHAR_UPPER_A && b <= tfs_pkg::CHAR_UPPER_Z) ? b + 8'd32 : b;
    if (content_count != tfs_pkg::POS_MAX) begin
      for (int i = 0; i < tfs_pkg::PREFIX_COUNT; i++) begin
        t = opening_text(i);
        if (content_count < t.len() && low != t[content_count]) begin
          opening_alive[i] = 1'b0;
        end
      end
      content_count = content_count + 4'd1;
    end
  endfunction

  // A line counts once its first non-blank byte shows up.
  function void note_line(input logic [7:0] b);
    if (line_count != tfs_pkg::LINES_MAX) begin
      line_count = line_count + 2'd1;
    end
    if (b != tfs_pkg::CHAR_BRACE) begin
      lines_all_brace = 1'b0;
    end
    at_line_start = 1'b0;
  endfunction

  function tfs_pkg::format_t classify_document();
    string t;
    if (!seen_content) begin
      return tfs_pkg::FMT_YAML;
    end
    for (int i = 0; i < tfs_pkg::PREFIX_COUNT; i++) begin
      t = opening_text(i);
      if (opening_alive[i] && content_count >= t.len()) begin
        return tfs_pkg::FMT_HTML;
      end
    end
    if (lead_byte == tfs_pkg::CHAR_ANGLE) begin
      return tfs_pkg::FMT_XML;
    end
    if (lead_byte == tfs_pkg::CHAR_SQUARE) begin
      return tfs_pkg::FMT_JSON;
    end
    if (lead_byte == tfs_pkg::CHAR_BRACE) begin
      return (lines_all_brace && line_count == tfs_pkg::LINES_MAX) ? tfs_pkg::FMT_JSONL
                                                                    : tfs_pkg::FMT_JSON;
    end
    return tfs_pkg::FMT_YAML;
  endfunction

  function void sniff_byte(input logic [7:0] b, input logic last);
    logic blank;
    blank = (b == tfs_pkg::CHAR_SPACE || b == tfs_pkg::CHAR_TAB || b == tfs_pkg::CHAR_CR);
    if (!seen_content) begin
      if (!blank && b != tfs_pkg::CHAR_LF) begin
        seen_content = 1'b1;
        lead_byte    = b;
        track_openings(b);
        note_line(b);
      end
    end else begin
      track_openings(b);
      if (b == tfs_pkg::CHAR_LF) begin
        at_line_start = 1'b1;
      end else if (at_line_start && !blank) begin
        note_line(b);
      end
    end
    if (last) begin
      expected_codes.push_back(classify_document());
      clear_sniff_state();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker. Every code word taken from the unit is matched against the
  // oldest prediction; inputs and outputs are sampled at the rising edge, before
  // any nonblocking update of that edge lands.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    tfs_pkg::format_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_codes.size() == 0) begin
        $error("format_code: no result expected, got %0d", format_code);
        failures++;
      end else begin
        want = expected_codes.pop_front();
        if (format_code !== want) begin
          $error("format_code: expected %0d, got %0d", want, format_code);
          failures++;
        end
      end
    end
  end

  // The receiver stalls on a pattern that changes each time window_count wraps: always
  // ready, coin flips, a repeating random mask, or mostly stalled.
  logic [5:0]  window_count = 6'd0;
  logic [1:0]  ready_mode   = 2'd0;
  logic [15:0] ready_mask   = 16'hFFFF;

  always @(posedge clk) begin
    window_count <= window_count + 6'd1;
    if (window_count == 6'd63) begin
      ready_mode <= 2'($urandom_range(0, 3));
      ready_mask <= 16'($urandom) | 16'h0001;
    end
    case (ready_mode)
      2'd0:    out_ready <= 1'b1;
      2'd1:    out_ready <= 1'($urandom_range(0, 1));
      2'd2:    out_ready <= ready_mask[window_count[3:0]];
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("text_format_sniffer_unit regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender. Words go out in bursts of random length; between bursts the valid
  // line drops for a random gap, and some bursts follow with no gap at all.
  // ---------------------------------------------------------------------------
  int burst_left = 1;

  task send_word(input logic [7:0] b, input logic last);
    int gap;
    in_valid    <= 1'b1;
    text_byte   <= b;
    end_of_text <= last;
    do begin
      @(posedge clk);
    end while (!(in_valid && in_ready));
    sniff_byte(b, last);
    bytes_sent++;
    burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Document under construction; send_document ships it with the last flag on
  // its final byte and empties it.
  logic [7:0] doc_bytes [$];

  task send_document();
    for (int i = 0; i < doc_bytes.size(); i++) begin
      send_word(doc_bytes[i], i == doc_bytes.size() - 1);
    end
    doc_bytes.delete();
  endtask

  // Appends text, optionally flipping random lower-case letters to upper case.
  task add_text(input string s, input bit mixed_case);
    logic [7:0] c;
    for (int k = 0; k < s.len(); k++) begin
      c = s[k];
      if (mixed_case && c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z && $urandom_range(0, 1)) begin
        c = c - 8'd32;
      end
      doc_bytes.push_back(c);
    end
  endtask

  task add_blanks(input int n, input bit with_lf);
    int pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, with_lf ? 3 : 2);
      case (pick)
        0:       doc_bytes.push_back(tfs_pkg::CHAR_SPACE);
        1:       doc_bytes.push_back(tfs_pkg::CHAR_TAB);
        2:       doc_bytes.push_back(tfs_pkg::CHAR_CR);
        default: doc_bytes.push_back(tfs_pkg::CHAR_LF);
      endcase
    end
  endtask

  // Printable filler, with an occasional line break when asked for.
  task add_filler(input int n, input bit with_lf);
    for (int k = 0; k < n; k++) begin
      if (with_lf && $urandom_range(0, 7) == 0) begin
        doc_bytes.push_back(tfs_pkg::CHAR_LF);
      end else begin
        doc_bytes.push_back(8'($urandom_range(32, 126)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests.
  // ---------------------------------------------------------------------------

  // Documents with no content byte at all come out as YAML.
  task test_blank_documents();
    doc_bytes.push_back(tfs_pkg::CHAR_SPACE);
    send_document();
    doc_bytes = '{tfs_pkg::CHAR_SPACE, tfs_pkg::CHAR_TAB, tfs_pkg::CHAR_CR, tfs_pkg::CHAR_LF};
    send_document();
  endtask

  // Each HTML opening in assorted case, one behind leading blanks, and one cut
  // short so that it falls back to XML.
  task test_html_openings();
    add_text("<!DocType HTML", 0);
    send_document();
    doc_bytes = '{tfs_pkg::CHAR_LF, tfs_pkg::CHAR_SPACE};
    add_text("<HtMl>", 0);
    send_document();
    add_text("<body", 0);
    send_document();
    add_text("<DIV", 0);
    send_document();
    add_text("<head", 0);
    send_document();
    add_text("<htm", 0);
    send_document();
  endtask

  // First content byte decides the rest: brackets, angle, plain text, and
  // non-ASCII bytes that must not be case folded.
  task test_leading_byte_kinds();
    add_text("[1]", 0);
    send_document();
    add_text("<a/>", 0);
    send_document();
    add_text("k: v", 0);
    send_document();
    doc_bytes = '{8'hFF, 8'h00};
    send_document();
    // 0xC8 is 'H' with the top bit set; it must not match "<html".
    doc_bytes = '{tfs_pkg::CHAR_ANGLE, 8'hC8, 8'h54, 8'h4D, 8'h4C};
    send_document();
  endtask

  // Line rules behind a leading brace: two brace lines, blank lines in between,
  // a stray line, a single line, and a brace followed only by empty lines.
  task test_brace_lines();
    add_text("{a}", 0);
    doc_bytes.push_back(tfs_pkg::CHAR_LF);
    add_text("{b}", 0);
    send_document();
    add_text("{a}", 0);
    doc_bytes.push_back(tfs_pkg::CHAR_LF);
    doc_bytes.push_back(tfs_pkg::CHAR_TAB);
    doc_bytes.push_back(tfs_pkg::CHAR_SPACE);
    doc_bytes.push_back(tfs_pkg::CHAR_CR);
    doc_bytes.push_back(tfs_pkg::CHAR_LF);
    add_text("  {b}", 0);
    doc_bytes.push_back(tfs_pkg::CHAR_LF);
    send_document();
    add_text("{a}", 0);
    doc_bytes.push_back(tfs_pkg::CHAR_LF);
    add_text(" x", 0);
    send_document();
    add_text("{}", 0);
    send_document();
    doc_bytes = '{tfs_pkg::CHAR_BRACE, tfs_pkg::CHAR_LF, tfs_pkg::CHAR_LF};
    send_document();
  endtask

  // ---------------------------------------------------------------------------
  // Random documents. Most are well formed with random content so that every
  // classification path is exercised; the rest are raw byte noise.
  // ---------------------------------------------------------------------------
  task test_random_documents();
    int    start_count;
    int    kind;
    int    which;
    int    cut;
    int    first_idx;
    int    n_lines;
    int    odd_line;
    bit    stray;
    string t;
    start_count = bytes_sent;
    while (bytes_sent - start_count < RANDOM_BYTES) begin
      kind = $urandom_range(0, 19);
      add_blanks($urandom_range(0, 2) == 0 ? $urandom_range(1, 4) : 0, 1);
      if (kind < 5) begin
        // HTML opening, sometimes cut short or with one byte corrupted.
        which = $urandom_range(0, tfs_pkg::PREFIX_COUNT - 1);
        t = opening_text(which);
        cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, t.len() - 1) : t.len();
        first_idx = doc_bytes.size();
        add_text(t.substr(0, cut - 1), 1);
        if ($urandom_range(0, 4) == 0) begin
          doc_bytes[first_idx + $urandom_range(0, cut - 1)] = 8'($urandom);
        end
        add_filler($urandom_range(0, 12), 1);
      end else if (kind < 7) begin
        doc_bytes.push_back(tfs_pkg::CHAR_ANGLE);
        add_filler($urandom_range(0, 10), 1);
      end else if (kind < 8) begin
        doc_bytes.push_back(tfs_pkg::CHAR_SQUARE);
        add_filler($urandom_range(0, 10), 1);
      end else if (kind < 13) begin
        // Brace lines with blank lines and indentation; sometimes one line
        // starts with something else.
        n_lines  = $urandom_range(1, 4);
        stray    = ($urandom_range(0, 3) == 0);
        odd_line = $urandom_range(1, 4);
        doc_bytes.push_back(tfs_pkg::CHAR_BRACE);
        add_filler($urandom_range(0, 5), 0);
        for (int l = 1; l < n_lines; l++) begin
          doc_bytes.push_back(tfs_pkg::CHAR_LF);
          if ($urandom_range(0, 2) == 0) begin
            add_blanks($urandom_range(0, 3), 0);
            doc_bytes.push_back(tfs_pkg::CHAR_LF);
          end
          add_blanks($urandom_range(0, 2), 0);
          if (stray && l == odd_line) begin
            doc_bytes.push_back(8'($urandom_range(33, 126)));
          end else begin
            doc_bytes.push_back(tfs_pkg::CHAR_BRACE);
          end
          add_filler($urandom_range(0, 5), 0);
        end
        if ($urandom_range(0, 1)) begin
          doc_bytes.push_back(tfs_pkg::CHAR_LF);
        end
      end else if (kind < 15) begin
        doc_bytes.push_back(8'($urandom_range(CHAR_LOWER_A, CHAR_LOWER_Z)));
        add_filler($urandom_range(0, 14), 1);
      end else if (kind < 16) begin
        add_blanks($urandom_range(1, 5), 1);
      end else begin
        // Raw noise, now and then long enough to run the position counter out.
        if ($urandom_range(0, 4) == 0) begin
          cut = $urandom_range(30, 45);
        end else begin
          cut = $urandom_range(1, 24);
        end
        for (int k = 0; k < cut; k++) begin
          doc_bytes.push_back(8'($urandom));
        end
      end
      send_document();
    end
  endtask

  initial begin
    clear_sniff_state();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_blank_documents();
    test_html_openings();
    test_leading_byte_kinds();
    test_brace_lines();
    test_random_documents();

    // Let the last code words drain, then keep the unit quiet for DRAIN_CYCLES in case
    // it produces something it should not.
    in_valid <= 1'b0;
    while (expected_codes.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_codes.size() != 0) begin
      $error("format_code: %0d expected results never arrived", expected_codes.size());
      failures++;
    end

    if (failures == 0) begin
      $display("text_format_sniffer_unit regression: pass");
    end else begin
      $display("text_format_sniffer_unit regression: fail");
    end
    $finish;
  end

endmodule
